### src/kms_pkg.sv
// shared types and constants of the k-medoids medoid select block
package kms_pkg;

  localparam int MAX_POINTS_DEF   = 256;
  localparam int MAX_DIMS_DEF     = 8;
  localparam int MAX_CLUSTERS_DEF = 16;

  localparam int COORD_W    = 16;
  localparam int LABEL_W    = 4;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;
  localparam int NCLUS_W    = 5;
  localparam int DIMS_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS         = 1'b1;

  localparam logic [NCLUS_W-1:0] NCLUS_RST = 5'd1;
  localparam logic [DIMS_W-1:0]  DIMS_RST  = 4'd8;

  typedef struct packed {
    logic [LABEL_W-1:0]        cluster_id;
    logic signed [COORD_W-1:0] coord_0;
    logic signed [COORD_W-1:0] coord_1;
    logic signed [COORD_W-1:0] coord_2;
    logic signed [COORD_W-1:0] coord_3;
    logic signed [COORD_W-1:0] coord_4;
    logic signed [COORD_W-1:0] coord_5;
    logic signed [COORD_W-1:0] coord_6;
    logic signed [COORD_W-1:0] coord_7;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic [LABEL_W-1:0]        cluster;
    logic [INDEX_W-1:0]        medoid_index;
    logic signed [COORD_W-1:0] medoid_coord_0;
    logic signed [COORD_W-1:0] medoid_coord_1;
    logic signed [COORD_W-1:0] medoid_coord_2;
    logic signed [COORD_W-1:0] medoid_coord_3;
    logic signed [COORD_W-1:0] medoid_coord_4;
    logic signed [COORD_W-1:0] medoid_coord_5;
    logic signed [COORD_W-1:0] medoid_coord_6;
    logic signed [COORD_W-1:0] medoid_coord_7;
    logic                      last_medoid;
  } out_beat_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sq_stat_t;

endpackage

### src/kms_isqrt.sv
// iterative floor square root, one result bit per cycle
module kms_isqrt import kms_pkg::*; #(
  parameter int SQW = 35,
  parameter int RW  = (SQW + 1) / 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [SQW-1:0] x,
  output sq_stat_t       stat,
  output logic [RW-1:0]  root
);

  localparam int CNW = $clog2(RW + 1);

  logic [2*RW-1:0] x_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNW-1:0]  cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+1:0]   rem_t;
  logic [RW+1:0]   trial;

  assign rem_t = {rem_r[RW-1:0], x_r[2*RW-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        x_r    <= (2*RW)'(x);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        x_r <= x_r << 2;
        if (rem_t >= trial) begin
          rem_r  <= rem_t - trial;
          root_r <= {root_r[RW-2:0], 1'b1};
        end else begin
          rem_r  <= rem_t;
          root_r <= {root_r[RW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNW'(RW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign root      = root_r;

endmodule

### src/kms_point_mem.sv
// point memory: coordinate rows and labels, registered read
module kms_point_mem import kms_pkg::*; #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int ROW_W = 128
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [ROW_W-1:0]   wrow,
  input  logic [LABEL_W-1:0] wlabel,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [ROW_W-1:0]   rrow,
  output logic [LABEL_W-1:0] rlabel
);

  logic [ROW_W-1:0]   row_mem [DEPTH];
  logic [LABEL_W-1:0] lab_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      row_mem[waddr] <= wrow;
      lab_mem[waddr] <= wlabel;
    end
    if (re) begin
      rrow   <= row_mem[raddr];
      rlabel <= lab_mem[raddr];
    end
  end

endmodule

### src/kmedoid_medoid_select_core.sv
// top level: point load, pair walk sequencer, per-cluster best table, result register
// Points load at one per cycle into a point memory (in_stall stays low while loading).
// The point with last_point set starts a burst in which in_stall is high: every stored
// point is read in turn; for a point whose label is reported, every stored point is
// then read again, each same-cluster partner adds a multiply-accumulate over the dims
// coordinates plus a pass of the bit-serial square root unit, and the best table is
// then updated; the burst cost is thus set by the square of the point count.
// The results then leave one per cluster in cluster order, each held while out_stall
// is high, and loading resumes.
module kmedoid_medoid_select_core import kms_pkg::*; #(
  parameter int MAX_POINTS   = MAX_POINTS_DEF,
  parameter int MAX_DIMS     = MAX_DIMS_DEF,
  parameter int MAX_CLUSTERS = MAX_CLUSTERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_beat_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int PW    = $clog2(MAX_POINTS);
  localparam int NW    = $clog2(MAX_POINTS + 1);
  localparam int CW    = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW    = $clog2(MAX_CLUSTERS + 1);
  localparam int DW    = $clog2(MAX_DIMS + 1);
  localparam int JW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int SQW   = 2 * COORD_W + $clog2(MAX_DIMS);
  localparam int RW    = (SQW + 1) / 2;
  localparam int SUMW  = RW + NW;
  localparam int BW    = SUMW + PW;
  localparam int ROW_W = MAX_DIMS * COORD_W;
  localparam int NCO   = 8;

  typedef enum logic [3:0] {
    S_LOAD, S_A_RD, S_A_WT, S_B_RD, S_B_WT, S_ACC, S_SQ, S_UPD, S_OUT, S_OUT_P, S_OUT_WT
  } state_t;

  typedef logic [MAX_DIMS-1:0][COORD_W-1:0] row_t;

  state_t               state_r;
  logic [NCLUS_W-1:0]   num_clusters_r;
  logic [DIMS_W-1:0]    dims_r;
  logic [NW-1:0]        cnt_r;
  logic [NW-1:0]        a_r;
  logic [NW-1:0]        b_r;
  logic [DW-1:0]        j_r;
  logic [KW-1:0]        k_r;
  row_t                 row_a_r;
  row_t                 row_b_r;
  logic [LABEL_W-1:0]   lab_a_r;
  logic [SQW-1:0]       sq_r;
  logic [SUMW-1:0]      sum_r;
  logic [MAX_CLUSTERS-1:0] seen_r;
  logic [BW-1:0]        best_mem [MAX_CLUSTERS];
  logic [BW-1:0]        best_rd_r;
  logic                 out_valid_r;
  out_beat_t            out_r;

  logic [KW-1:0]        nk;
  logic [DW-1:0]        nd;
  logic                 in_acc;
  logic                 pm_we;
  logic                 pm_re;
  logic [PW-1:0]        pm_raddr;
  logic [ROW_W-1:0]     pm_rrow;
  logic [LABEL_W-1:0]   pm_rlabel;
  row_t                 rd_row;
  row_t                 in_row;
  logic [NCO-1:0][COORD_W-1:0] in_c;
  logic [NCO-1:0][COORD_W-1:0] o_c;
  logic                 best_re;
  logic [CW-1:0]        best_raddr;
  logic                 best_we;
  logic [PW-1:0]        p_sel;
  logic signed [COORD_W:0]     dif;
  logic signed [2*COORD_W+1:0] prod;
  logic                 sq_start;
  sq_stat_t             sq_stat;
  logic [RW-1:0]        sq_root;
  logic                 out_load;

  assign nk = (int'(num_clusters_r) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) : KW'(num_clusters_r);
  assign nd = (int'(dims_r) > MAX_DIMS) ? DW'(MAX_DIMS) : DW'(dims_r);

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign pm_we    = in_acc && (int'(cnt_r) < MAX_POINTS);

  assign in_c[0] = in_data.coord_0;
  assign in_c[1] = in_data.coord_1;
  assign in_c[2] = in_data.coord_2;
  assign in_c[3] = in_data.coord_3;
  assign in_c[4] = in_data.coord_4;
  assign in_c[5] = in_data.coord_5;
  assign in_c[6] = in_data.coord_6;
  assign in_c[7] = in_data.coord_7;

  always_comb begin
    for (int j = 0; j < MAX_DIMS; j++) begin
      in_row[j] = in_c[j];
    end
  end

  assign rd_row = row_t'(pm_rrow);
  assign p_sel  = seen_r[CW'(k_r)] ? best_rd_r[PW-1:0] : '0;

  always_comb begin
    pm_re    = 1'b0;
    pm_raddr = a_r[PW-1:0];
    unique case (state_r)
      S_A_RD: begin
        pm_re    = (a_r != cnt_r);
        pm_raddr = a_r[PW-1:0];
      end
      S_B_RD: begin
        pm_re    = (b_r != cnt_r);
        pm_raddr = b_r[PW-1:0];
      end
      S_OUT_P: begin
        pm_re    = 1'b1;
        pm_raddr = p_sel;
      end
      default: begin
        pm_re = 1'b0;
      end
    endcase
  end

  kms_point_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (PW),
    .ROW_W (ROW_W)
  ) u_mem (
    .clk    (clk),
    .we     (pm_we),
    .waddr  (cnt_r[PW-1:0]),
    .wrow   (ROW_W'(in_row)),
    .wlabel (in_data.cluster_id),
    .re     (pm_re),
    .raddr  (pm_raddr),
    .rrow   (pm_rrow),
    .rlabel (pm_rlabel)
  );

  // squared distance term of the current coordinate
  assign dif  = {row_a_r[j_r[JW-1:0]][COORD_W-1], row_a_r[j_r[JW-1:0]]}
              - {row_b_r[j_r[JW-1:0]][COORD_W-1], row_b_r[j_r[JW-1:0]]};
  assign prod = dif * dif;

  assign sq_start = (state_r == S_ACC) && (j_r == nd);

  kms_isqrt #(
    .SQW (SQW),
    .RW  (RW)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .x     (sq_r),
    .stat  (sq_stat),
    .root  (sq_root)
  );

  // best score table
  assign best_re    = (state_r == S_A_WT) || ((state_r == S_OUT) && (k_r != nk));
  assign best_raddr = (state_r == S_A_WT) ? CW'(pm_rlabel) : CW'(k_r);
  assign best_we    = (state_r == S_UPD) &&
                      (!seen_r[CW'(lab_a_r)] || (sum_r < best_rd_r[BW-1:PW]));

  always_ff @(posedge clk) begin
    if (best_we) begin
      best_mem[CW'(lab_a_r)] <= {sum_r, a_r[PW-1:0]};
    end
    if (best_re) begin
      best_rd_r <= best_mem[best_raddr];
    end
  end

  assign out_load = (state_r == S_OUT_WT) && (!out_valid_r || !out_stall);

  always_comb begin
    for (int j = 0; j < NCO; j++) begin
      o_c[j] = '0;
      if (j < MAX_DIMS && j < int'(nd)) begin
        o_c[j] = rd_row[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_LOAD;
      num_clusters_r <= NCLUS_RST;
      dims_r         <= DIMS_RST;
      cnt_r          <= '0;
      a_r            <= '0;
      b_r            <= '0;
      j_r            <= '0;
      k_r            <= '0;
      seen_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_NUM_CLUSTERS: num_clusters_r <= cfg_data[NCLUS_W-1:0];
          REG_DIMS:         dims_r         <= cfg_data[DIMS_W-1:0];
          default:          ;
        endcase
      end
      out_valid_r <= out_load || (out_valid_r && out_stall);
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            cnt_r <= cnt_r + NW'(pm_we);
            if (in_data.last_point) begin
              a_r     <= '0;
              seen_r  <= '0;
              state_r <= S_A_RD;
            end
          end
        end
        S_A_RD: begin
          if (a_r == cnt_r) begin
            k_r     <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_A_WT;
          end
        end
        S_A_WT: begin
          row_a_r <= rd_row;
          lab_a_r <= pm_rlabel;
          if (int'(pm_rlabel) < int'(nk)) begin
            sum_r   <= '0;
            b_r     <= '0;
            state_r <= S_B_RD;
          end else begin
            a_r     <= a_r + 1'b1;
            state_r <= S_A_RD;
          end
        end
        S_B_RD: begin
          state_r <= (b_r == cnt_r) ? S_UPD : S_B_WT;
        end
        S_B_WT: begin
          row_b_r <= rd_row;
          if (b_r == a_r || pm_rlabel != lab_a_r) begin
            b_r     <= b_r + 1'b1;
            state_r <= S_B_RD;
          end else begin
            j_r     <= '0;
            sq_r    <= '0;
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (j_r == nd) begin
            state_r <= S_SQ;
          end else begin
            sq_r <= sq_r + SQW'(prod[2*COORD_W-1:0]);
            j_r  <= j_r + 1'b1;
          end
        end
        S_SQ: begin
          if (sq_stat.done) begin
            sum_r   <= sum_r + SUMW'(sq_root);
            b_r     <= b_r + 1'b1;
            state_r <= S_B_RD;
          end
        end
        S_UPD: begin
          if (best_we) begin
            seen_r[CW'(lab_a_r)] <= 1'b1;
          end
          a_r     <= a_r + 1'b1;
          state_r <= S_A_RD;
        end
        S_OUT: begin
          if (k_r == nk) begin
            cnt_r   <= '0;
            state_r <= S_LOAD;
          end else begin
            state_r <= S_OUT_P;
          end
        end
        S_OUT_P: begin
          state_r <= S_OUT_WT;
        end
        S_OUT_WT: begin
          if (out_load) begin
            out_r.cluster        <= LABEL_W'(k_r);
            out_r.medoid_index   <= INDEX_W'(p_sel);
            out_r.medoid_coord_0 <= o_c[0];
            out_r.medoid_coord_1 <= o_c[1];
            out_r.medoid_coord_2 <= o_c[2];
            out_r.medoid_coord_3 <= o_c[3];
            out_r.medoid_coord_4 <= o_c[4];
            out_r.medoid_coord_5 <= o_c[5];
            out_r.medoid_coord_6 <= o_c[6];
            out_r.medoid_coord_7 <= o_c[7];
            out_r.last_medoid    <= (k_r + 1'b1 == nk);
            k_r                  <= k_r + 1'b1;
            state_r              <= S_OUT;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(cnt_r) <= MAX_POINTS)
    else $error("point count beyond capacity");

  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result beat changed");

endmodule
